[rtl/lsbbuf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbbuf_pkg
// Shared types and constants for the LSB-first bit stream buffer.
// ----------------------------------------------------------------------------
package lsbbuf_pkg;

   // Field widths of the request and response beats
   localparam int OP_W     = 3;
   localparam int VAL_W    = 32;
   localparam int CNT_W    = 6;
   localparam int BITPOS_W = 3;
   localparam int ADDR_W   = 12;
   localparam int BYTE_W   = 8;

   // Address reduction takes one compare/subtract per address bit
   localparam int MOD_STEPS = ADDR_W;
   localparam int MODCNT_W  = $clog2(MOD_STEPS);

   // Defaults for the top-level parameters
   localparam int DEF_BUFFER_DEPTH = 4096;
   localparam int DEF_MAX_COUNT    = 32;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE    = 3'd0,
      OP_READ     = 3'd1,
      OP_SET_BIT  = 3'd2,
      OP_SET_BYTE = 3'd3,
      OP_PEEK     = 3'd4
   } opcode_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch request beat
      logic set_bit;    // load bit cursor from request
      logic mod_step;   // one step of address reduction
      logic fetch_cur;  // read byte at cursor
      logic fetch_rem;  // read byte at reduced address
      logic update;     // consume one byte chunk
      logic wr;         // chunk is a write
      logic set_byte;   // load byte cursor from reduced address
      logic load_rsp;   // load response registers
      logic peek_out;   // response carries peeked byte
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cnt_zero;   // no bits left in this op
      logic mod_last;   // current reduction step is the last
   } sts_type;

endpackage

[rtl/lsb_first_bit_stream_buffer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_stream_buffer_unit
// Byte buffer with a bit cursor: packs and unpacks up to MAX_COUNT bits LSB
// first, moves the cursor and peeks single bytes.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall opcode, write_value, bit_count,
//                                           new_bit_position, byte_address
//   rsp      out        rsp_valid/rsp_stall read_value, bit_position,
//                                           byte_position, peeked_byte
//
// Write/read: each of the B bytes touched (B = 0..5) is fetched, then updated;
//   a write makes each byte a read-modify-write on the single-port byte store.
// Set byte position and peek: a 12-step address reduction modulo BUFFER_DEPTH,
//   then cursor load or byte fetch. Set bit position and others skip both.
// Reset clears cursor and handshake state; store contents are undefined.
// A new request beat is taken while a response beat waits under rsp_stall.
// ----------------------------------------------------------------------------
module lsb_first_bit_stream_buffer_unit #(
   parameter int BUFFER_DEPTH = lsbbuf_pkg::DEF_BUFFER_DEPTH,
   parameter int MAX_COUNT    = lsbbuf_pkg::DEF_MAX_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lsbbuf_pkg::OP_W-1:0]         req_opcode,
   input  logic [lsbbuf_pkg::VAL_W-1:0]        req_write_value,
   input  logic [lsbbuf_pkg::CNT_W-1:0]        req_bit_count,
   input  logic [lsbbuf_pkg::BITPOS_W-1:0]     req_new_bit_position,
   input  logic [lsbbuf_pkg::ADDR_W-1:0]       req_byte_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lsbbuf_pkg::VAL_W-1:0]        rsp_read_value,
   output logic [lsbbuf_pkg::BITPOS_W-1:0]     rsp_bit_position,
   output logic [lsbbuf_pkg::ADDR_W-1:0]       rsp_byte_position,
   output logic [lsbbuf_pkg::BYTE_W-1:0]       rsp_peeked_byte
);

   lsbbuf_pkg::cmd_type cmd;
   lsbbuf_pkg::sts_type sts;

   // Sequencer
   lsbbuf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Store, cursor and response registers
   lsbbuf_dpath #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_COUNT    (MAX_COUNT)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_write_value      (req_write_value),
      .req_bit_count        (req_bit_count),
      .req_new_bit_position (req_new_bit_position),
      .req_byte_address     (req_byte_address),
      .rsp_read_value       (rsp_read_value),
      .rsp_bit_position     (rsp_bit_position),
      .rsp_byte_position    (rsp_byte_position),
      .rsp_peeked_byte      (rsp_peeked_byte)
   );

endmodule

[rtl/lsbbuf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbbuf_ctrl
// Sequencer: accepts a request beat, steps the datapath through the op and
// hands the response beat to the output register.
// ----------------------------------------------------------------------------
module lsbbuf_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lsbbuf_pkg::OP_W-1:0]      req_opcode,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  lsbbuf_pkg::sts_type              sts,
   output lsbbuf_pkg::cmd_type              cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHUNK,
      S_UPDATE,
      S_MOD,
      S_PLACE,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   lsbbuf_pkg::opcode_type op_ff, op_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = lsbbuf_pkg::opcode_type'(req_opcode);
               case (req_opcode)
                  lsbbuf_pkg::OP_WRITE,
                  lsbbuf_pkg::OP_READ: begin
                     state_in = S_CHUNK;
                  end
                  lsbbuf_pkg::OP_SET_BIT: begin
                     cmd.set_bit = 1'b1;
                     state_in    = S_FINISH;
                  end
                  lsbbuf_pkg::OP_SET_BYTE,
                  lsbbuf_pkg::OP_PEEK: begin
                     state_in = S_MOD;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_CHUNK: begin
            if (sts.cnt_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.fetch_cur = 1'b1;
               state_in      = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            cmd.wr     = (op_ff == lsbbuf_pkg::OP_WRITE);
            state_in   = S_CHUNK;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (op_ff == lsbbuf_pkg::OP_PEEK) begin
               cmd.fetch_rem = 1'b1;
            end else begin
               cmd.set_byte = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // wait until the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               cmd.peek_out = (op_ff == lsbbuf_pkg::OP_PEEK);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= lsbbuf_pkg::OP_WRITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/lsbbuf_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbbuf_dpath
// Byte store, cursor, bit chunk packing/unpacking, address reduction and
// response registers.
// ----------------------------------------------------------------------------
module lsbbuf_dpath #(
   parameter int BUFFER_DEPTH = lsbbuf_pkg::DEF_BUFFER_DEPTH,
   parameter int MAX_COUNT    = lsbbuf_pkg::DEF_MAX_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lsbbuf_pkg::cmd_type                 cmd,
   output lsbbuf_pkg::sts_type                 sts,
   input  logic [lsbbuf_pkg::VAL_W-1:0]        req_write_value,
   input  logic [lsbbuf_pkg::CNT_W-1:0]        req_bit_count,
   input  logic [lsbbuf_pkg::BITPOS_W-1:0]     req_new_bit_position,
   input  logic [lsbbuf_pkg::ADDR_W-1:0]       req_byte_address,
   output logic [lsbbuf_pkg::VAL_W-1:0]        rsp_read_value,
   output logic [lsbbuf_pkg::BITPOS_W-1:0]     rsp_bit_position,
   output logic [lsbbuf_pkg::ADDR_W-1:0]       rsp_byte_position,
   output logic [lsbbuf_pkg::BYTE_W-1:0]       rsp_peeked_byte
);

   localparam int MEM_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int DEP_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int DSH_W  = DEP_W + lsbbuf_pkg::MOD_STEPS - 1;
   localparam int CHK_W  = lsbbuf_pkg::CNT_W + 1;
   localparam int NUM_W  = $clog2(lsbbuf_pkg::BYTE_W + 1);

   localparam logic [MEM_AW-1:0]              LAST_ADDR = MEM_AW'(BUFFER_DEPTH - 1);
   localparam logic [lsbbuf_pkg::CNT_W-1:0]   CNT_MAX   = lsbbuf_pkg::CNT_W'(MAX_COUNT);
   localparam logic [DSH_W-1:0]               DSH_INIT  =
      DSH_W'(BUFFER_DEPTH) << (lsbbuf_pkg::MOD_STEPS - 1);

   // Byte store
   logic [lsbbuf_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
   logic [lsbbuf_pkg::BYTE_W-1:0] rdata_ff;
   logic [MEM_AW-1:0]             rd_addr;

   // Cursor and op state
   logic [MEM_AW-1:0]                 cursor_ff, cursor_in;
   logic [lsbbuf_pkg::BITPOS_W-1:0]   bit_ff, bit_in;
   logic [lsbbuf_pkg::CNT_W-1:0]      cnt_left_ff, cnt_left_in;
   logic [lsbbuf_pkg::CNT_W-1:0]      done_ff, done_in;
   logic [lsbbuf_pkg::VAL_W-1:0]      val_ff, val_in;
   logic [lsbbuf_pkg::VAL_W-1:0]      rd_ff, rd_in;

   // Address reduction
   logic [lsbbuf_pkg::ADDR_W-1:0]     rem_ff, rem_in;
   logic [DSH_W-1:0]                  dsub_ff, dsub_in;
   logic [lsbbuf_pkg::MODCNT_W-1:0]   mod_cnt_ff, mod_cnt_in;

   // Response registers
   logic [lsbbuf_pkg::VAL_W-1:0]      rsp_rd_ff, rsp_rd_in;
   logic [lsbbuf_pkg::BITPOS_W-1:0]   rsp_bit_ff, rsp_bit_in;
   logic [lsbbuf_pkg::ADDR_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [lsbbuf_pkg::BYTE_W-1:0]     rsp_pk_ff, rsp_pk_in;

   // Chunk signals
   logic [NUM_W-1:0]                  room;
   logic [NUM_W-1:0]                  num;
   logic [lsbbuf_pkg::BYTE_W-1:0]     mask;
   logic [lsbbuf_pkg::BYTE_W-1:0]     ins_bits;
   logic [lsbbuf_pkg::BYTE_W-1:0]     wr_byte;
   logic [lsbbuf_pkg::BYTE_W-1:0]     chunk;
   logic [NUM_W-1:0]                  bit_sum;
   logic [MEM_AW-1:0]                 cursor_inc;
   logic [lsbbuf_pkg::CNT_W-1:0]      cnt_clamped;

   // Bits handled in this byte: the lesser of what is left and what fits
   always_comb begin
      room = NUM_W'(lsbbuf_pkg::BYTE_W) - NUM_W'(bit_ff);
      if (cnt_left_ff < lsbbuf_pkg::CNT_W'(room)) begin
         num = NUM_W'(cnt_left_ff);
      end else begin
         num = room;
      end
      mask       = lsbbuf_pkg::BYTE_W'((9'd1 << num) - 9'd1);
      ins_bits   = (val_ff[lsbbuf_pkg::BYTE_W-1:0] & mask) << bit_ff;
      // first bit at position zero replaces the byte
      wr_byte    = ((bit_ff == '0) ? '0 : rdata_ff) | ins_bits;
      chunk      = (rdata_ff >> bit_ff) & mask;
      bit_sum    = NUM_W'(bit_ff) + num;
      cursor_inc = (cursor_ff == LAST_ADDR) ? '0 : cursor_ff + 1'b1;
      cnt_clamped = (req_bit_count > CNT_MAX) ? CNT_MAX : req_bit_count;
   end

   // Next values
   always_comb begin
      cursor_in   = cursor_ff;
      bit_in      = bit_ff;
      cnt_left_in = cnt_left_ff;
      done_in     = done_ff;
      val_in      = val_ff;
      rd_in       = rd_ff;
      rem_in      = rem_ff;
      dsub_in     = dsub_ff;
      mod_cnt_in  = mod_cnt_ff;
      rsp_rd_in   = rsp_rd_ff;
      rsp_bit_in  = rsp_bit_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_pk_in   = rsp_pk_ff;

      if (cmd.capture) begin
         cnt_left_in = cnt_clamped;
         done_in     = '0;
         val_in      = req_write_value;
         rd_in       = '0;
         rem_in      = req_byte_address;
         dsub_in     = DSH_INIT;
         mod_cnt_in  = lsbbuf_pkg::MODCNT_W'(lsbbuf_pkg::MOD_STEPS - 1);
      end
      if (cmd.set_bit) begin
         bit_in = req_new_bit_position;
      end

      // restoring reduction, one shifted depth per step
      if (cmd.mod_step) begin
         if (DSH_W'(rem_ff) >= dsub_ff) begin
            rem_in = rem_ff - dsub_ff[lsbbuf_pkg::ADDR_W-1:0];
         end
         dsub_in    = dsub_ff >> 1;
         mod_cnt_in = mod_cnt_ff - 1'b1;
      end
      if (cmd.set_byte) begin
         cursor_in = MEM_AW'(rem_ff);
      end

      // consume one byte chunk
      if (cmd.update) begin
         cnt_left_in = cnt_left_ff - lsbbuf_pkg::CNT_W'(num);
         done_in     = done_ff + lsbbuf_pkg::CNT_W'(num);
         val_in      = val_ff >> num;
         if (!cmd.wr) begin
            rd_in = rd_ff | (lsbbuf_pkg::VAL_W'(chunk) << done_ff);
         end
         if (bit_sum >= NUM_W'(lsbbuf_pkg::BYTE_W)) begin
            bit_in    = '0;
            cursor_in = cursor_inc;
         end else begin
            bit_in = lsbbuf_pkg::BITPOS_W'(bit_sum);
         end
      end

      if (cmd.load_rsp) begin
         rsp_rd_in  = rd_ff;
         rsp_bit_in = bit_ff;
         rsp_pos_in = lsbbuf_pkg::ADDR_W'(cursor_ff);
         rsp_pk_in  = cmd.peek_out ? rdata_ff : '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         bit_ff      <= '0;
         cnt_left_ff <= '0;
         done_ff     <= '0;
      end else begin
         cursor_ff   <= cursor_in;
         bit_ff      <= bit_in;
         cnt_left_ff <= cnt_left_in;
         done_ff     <= done_in;
      end
      val_ff     <= val_in;
      rd_ff      <= rd_in;
      rem_ff     <= rem_in;
      dsub_ff    <= dsub_in;
      mod_cnt_ff <= mod_cnt_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_pk_ff  <= rsp_pk_in;
   end

   // Memory: registered read, single write
   assign rd_addr = cmd.fetch_rem ? MEM_AW'(rem_ff) : cursor_ff;

   always_ff @(posedge clock) begin
      if (cmd.fetch_cur || cmd.fetch_rem) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && cmd.wr) begin
         mem[cursor_ff] <= wr_byte;
      end
   end

   assign sts.cnt_zero = (cnt_left_ff == '0);
   assign sts.mod_last = (mod_cnt_ff == '0);

   assign rsp_read_value    = rsp_rd_ff;
   assign rsp_bit_position  = rsp_bit_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_peeked_byte   = rsp_pk_ff;

   // Checks
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cursor_ff) < 32'(BUFFER_DEPTH)))
      else $error("byte cursor beyond store depth");

   a_chunk_progress: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (cnt_left_ff < $past(cnt_left_ff)))
      else $error("byte chunk consumed no bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CHK_W'(done_ff) + CHK_W'(cnt_left_ff) <= CHK_W'(MAX_COUNT)))
      else $error("bit count bookkeeping exceeds maximum");

   a_reduced_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.mod_step && sts.mod_last) |=> (32'(rem_ff) < 32'(BUFFER_DEPTH)))
      else $error("reduced address not below depth");

endmodule

[tb/lsb_first_bit_stream_buffer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_stream_buffer_unit_tb
// Self-checking bench for the LSB-first bit stream buffer. A directed block
// covers zero and over-range counts, aligned bytes, OR versus replace writes,
// cursor moves, peeks, byte position wrap and unused opcodes. A random part
// then runs write/read-back sequences over random spans, mixed with loose
// commands. Every beat is predicted by a shadow buffer and compared field by
// field, in order, against the response channel. Both sides idle at random.
// ----------------------------------------------------------------------------
module lsb_first_bit_stream_buffer_unit_tb;
   import lsbbuf_pkg::*;

   // Depth equals 2**ADDR_W, so cursor and address wrap come for free
   localparam int DEPTH        = DEF_BUFFER_DEPTH;
   localparam int MAXC         = DEF_MAX_COUNT;
   localparam int OP_LAST_CODE = (1 << OP_W) - 1;
   localparam int CNT_TOP      = (1 << CNT_W) - 1;
   localparam int CUR_W        = ADDR_W + BITPOS_W;
   localparam int N_ITEMS      = 1050;
   localparam int CALM_TAIL    = 120;
   localparam int DRAIN_EVERY  = 250;
   localparam int STUCK_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam int MAX_REPORTS  = 10;
   localparam int HALF         = 5;

   // Shadow copies: one advanced while building stimulus, one on accepted beats
   localparam int PLAN = 0;
   localparam int LIVE = 1;

   typedef enum int {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_t;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [VAL_W-1:0]    wval;
      logic [CNT_W-1:0]    cnt;
      logic [BITPOS_W-1:0] nbit;
      logic [ADDR_W-1:0]   addr;
   } bits_req_t;

   typedef struct packed {
      logic [VAL_W-1:0]    rdata;
      logic [BITPOS_W-1:0] bitpos;
      logic [ADDR_W-1:0]   bytepos;
      logic [BYTE_W-1:0]   peek;
   } bits_rsp_t;

   // A drain entry holds the sender until every response is back
   typedef struct packed {
      logic      drain;
      bits_req_t req;
   } stim_t;

   bit                   clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_opcode;
   logic [VAL_W-1:0]     req_write_value;
   logic [CNT_W-1:0]     req_bit_count;
   logic [BITPOS_W-1:0]  req_new_bit_position;
   logic [ADDR_W-1:0]    req_byte_address;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [VAL_W-1:0]     rsp_read_value;
   logic [BITPOS_W-1:0]  rsp_bit_position;
   logic [ADDR_W-1:0]    rsp_byte_position;
   logic [BYTE_W-1:0]    rsp_peeked_byte;

   // Shadow buffer state
   bit [BYTE_W-1:0]   byte_img [2][DEPTH];
   bit                written  [2][DEPTH];
   bit [ADDR_W-1:0]   cur_byte [2];
   bit [BITPOS_W-1:0] cur_bit  [2];

   stim_t     stim_q[$];
   bits_rsp_t due_rsp[$];
   bits_req_t on_wire;

   bit    req_took;
   bit    calm;
   pace_t send_pace;
   pace_t recv_pace;
   int    send_tick;
   int    recv_tick;
   int    gap_left;
   int    hold_left;
   int    stim_total;
   int    useful_items;
   int    beats_done;
   int    rsp_count;
   int    mismatches;
   int    stuck_cycles;
   int    op_tally [OP_LAST_CODE+1];

   lsb_first_bit_stream_buffer_unit #(
      .BUFFER_DEPTH(DEPTH),
      .MAX_COUNT   (MAXC)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_write_value     (req_write_value),
      .req_bit_count       (req_bit_count),
      .req_new_bit_position(req_new_bit_position),
      .req_byte_address    (req_byte_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_value      (rsp_read_value),
      .rsp_bit_position    (rsp_bit_position),
      .rsp_byte_position   (rsp_byte_position),
      .rsp_peeked_byte     (rsp_peeked_byte)
   );

   always begin
      #HALF clock = 1'b1;
      #HALF clock = 1'b0;
   end

   // Shadow buffer: applies one command and returns the response it gives
   function automatic bits_rsp_t step_buffer(int s, bits_req_t r);
      bits_rsp_t res;
      int        n;
      res = '0;
      n = (r.cnt > MAXC) ? MAXC : int'(r.cnt);
      case (r.op)
         OP_WRITE: begin
            for (int i = 0; i < n; i++) begin
               // bit 0 replaces the byte, other positions OR in
               if (cur_bit[s] == 0) begin
                  byte_img[s][cur_byte[s]] = BYTE_W'(r.wval[i]);
                  written[s][cur_byte[s]] = 1'b1;
               end else begin
                  byte_img[s][cur_byte[s]][cur_bit[s]] =
                     byte_img[s][cur_byte[s]][cur_bit[s]] | r.wval[i];
               end
               {cur_byte[s], cur_bit[s]} = {cur_byte[s], cur_bit[s]} + 1'b1;
            end
         end
         OP_READ: begin
            for (int i = 0; i < n; i++) begin
               res.rdata[i] = byte_img[s][cur_byte[s]][cur_bit[s]];
               {cur_byte[s], cur_bit[s]} = {cur_byte[s], cur_bit[s]} + 1'b1;
            end
         end
         OP_SET_BIT:  cur_bit[s] = r.nbit;
         OP_SET_BYTE: cur_byte[s] = r.addr;
         OP_PEEK:     res.peek = byte_img[s][r.addr];
         default: ;
      endcase
      res.bitpos  = cur_bit[s];
      res.bytepos = cur_byte[s];
      return res;
   endfunction

   // True when the command reads no byte that was never written; a mid-byte write reads its byte
   function automatic bit is_safe(bits_req_t r);
      int             n;
      logic [CUR_W-1:0] pos;
      n = (r.cnt > MAXC) ? MAXC : int'(r.cnt);
      pos = {cur_byte[PLAN], cur_bit[PLAN]};
      case (r.op)
         OP_WRITE: return n == 0 || cur_bit[PLAN] == 0 || written[PLAN][cur_byte[PLAN]];
         OP_READ: begin
            for (int i = 0; i < n; i++) begin
               if (!written[PLAN][pos[CUR_W-1:BITPOS_W]]) return 1'b0;
               pos = pos + 1'b1;
            end
            return 1'b1;
         end
         OP_PEEK: return written[PLAN][r.addr];
         default: return 1'b1;
      endcase
   endfunction

   function automatic bits_req_t rand_req(logic [OP_W-1:0] op);
      bits_req_t r;
      r.op   = op;
      r.wval = $urandom;
      r.cnt  = CNT_W'($urandom);
      r.nbit = BITPOS_W'($urandom);
      r.addr = ADDR_W'($urandom);
      return r;
   endfunction

   // Mostly in-range counts, with whole bytes, the maximum and over-range
   function automatic int pick_count();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return $urandom_range(MAXC + 1, CNT_TOP);
      if (roll <= 2) return BYTE_W;
      if (roll == 3) return MAXC;
      return $urandom_range(0, MAXC);
   endfunction

   function automatic bit burst_now(pace_t pace);
      case (pace)
         PACE_LIGHT: return $urandom_range(0, 7) == 0;
         PACE_HEAVY: return $urandom_range(0, 2) == 0;
         default:    return 1'b0;
      endcase
   endfunction

   task automatic queue_op(input bits_req_t r);
      stim_t e;
      void'(step_buffer(PLAN, r));
      e.drain = 1'b0;
      e.req   = r;
      stim_q.push_back(e);
      stim_total++;
      if (r.op <= OP_PEEK) useful_items++;
   endtask

   task automatic queue_cmd(input logic [OP_W-1:0] op, input int cnt,
                            input logic [VAL_W-1:0] wval, input int nbit, input int addr);
      bits_req_t r;
      r.op   = op;
      r.wval = wval;
      r.cnt  = CNT_W'(cnt);
      r.nbit = BITPOS_W'(nbit);
      r.addr = ADDR_W'(addr);
      queue_op(r);
   endtask

   task automatic queue_drain();
      stim_t e;
      e = '0;
      e.drain = 1'b1;
      stim_q.push_back(e);
   endtask

   // Request driver: beats change at the falling edge
   always @(negedge clock) begin
      stim_t nxt;
      if (!reset) begin
         send_tick++;
         if (send_tick % 128 == 0) send_pace = pace_t'($urandom_range(PACE_NONE, PACE_HEAVY));
         // retire the beat taken at the last rising edge
         if (req_valid && req_took) begin
            due_rsp.push_back(step_buffer(LIVE, on_wire));
            op_tally[on_wire.op]++;
            beats_done++;
         end
         if (req_valid && !req_took) begin
            // stalled beat holds its payload
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stim_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (stim_q[0].drain) begin
            if (due_rsp.size() == 0) void'(stim_q.pop_front());
            req_valid <= 1'b0;
         end else if (!calm && burst_now(send_pace)) begin
            gap_left = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else begin
            nxt = stim_q.pop_front();
            on_wire = nxt.req;
            {req_opcode, req_write_value, req_bit_count, req_new_bit_position,
             req_byte_address} <= nxt.req;
            req_valid <= 1'b1;
         end
      end
   end

   // Response back-pressure in random bursts
   always @(negedge clock) begin
      recv_tick++;
      if (recv_tick % 128 == 0) recv_pace = pace_t'($urandom_range(PACE_NONE, PACE_HEAVY));
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && !calm && burst_now(recv_pace)) begin
         hold_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: samples both channels at the rising edge
   always @(posedge clock) begin
      bits_rsp_t want;
      req_took <= req_valid && !req_stall;
      calm     <= stim_q.size() <= CALM_TAIL;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (due_rsp.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t: unexpected response beat: rd=%h bit=%0d byte=%0d peek=%h",
                        $time, rsp_read_value, rsp_bit_position, rsp_byte_position,
                        rsp_peeked_byte);
            mismatches++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_read_value !== want.rdata || rsp_bit_position !== want.bitpos ||
                rsp_byte_position !== want.bytepos || rsp_peeked_byte !== want.peek) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t: beat %0d mismatch: exp rd=%h bit=%0d byte=%0d peek=%h, %s",
                           $time, rsp_count, want.rdata, want.bitpos, want.bytepos, want.peek,
                           $sformatf("got rd=%h bit=%0d byte=%0d peek=%h", rsp_read_value,
                                     rsp_bit_position, rsp_byte_position, rsp_peeked_byte));
               mismatches++;
            end
         end
      end
   end

   // Stimulus build, reset and end of run
   initial begin
      bits_req_t         r;
      logic [ADDR_W-1:0] start;
      int                sbit;
      int                nfield;
      int                total;
      int                span;
      int                next_drain;
      int                unused_ops;
      int                cnts [6];

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_opcode           = '0;
      req_write_value      = '0;
      req_bit_count        = '0;
      req_new_bit_position = '0;
      req_byte_address     = '0;
      rsp_stall            = 1'b0;

      // Directed: zero counts, full words, over-range count, aligned byte
      queue_cmd(OP_WRITE, 0, $urandom, $urandom, $urandom);
      queue_cmd(OP_READ, 0, $urandom, $urandom, $urandom);
      queue_cmd(OP_WRITE, MAXC, '1, $urandom, $urandom);
      queue_cmd(OP_WRITE, CNT_TOP, 32'hA5C3_0F96, $urandom, $urandom);
      queue_cmd(OP_WRITE, BYTE_W, 32'h0000_005A, $urandom, $urandom);
      // OR zeros mid-byte, then a replace at the next byte boundary
      queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, 0);
      queue_cmd(OP_SET_BIT, $urandom, $urandom, 5, $urandom);
      queue_cmd(OP_WRITE, 13, '0, $urandom, $urandom);
      // read back, including an over-range count and an aligned byte
      queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, 0);
      queue_cmd(OP_READ, MAXC, $urandom, $urandom, $urandom);
      queue_cmd(OP_READ, 40, $urandom, $urandom, $urandom);
      queue_cmd(OP_READ, BYTE_W, $urandom, $urandom, $urandom);
      queue_cmd(OP_PEEK, $urandom, $urandom, $urandom, BYTE_W);
      queue_cmd(OP_PEEK, $urandom, $urandom, $urandom, 1);
      // byte position wrap past the last byte
      queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, DEPTH - 1);
      queue_cmd(OP_SET_BIT, $urandom, $urandom, 0, $urandom);
      queue_cmd(OP_WRITE, MAXC, $urandom, $urandom, $urandom);
      queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, DEPTH - 1);
      queue_cmd(OP_READ, MAXC, $urandom, $urandom, $urandom);
      // unused opcodes leave the cursor alone
      queue_cmd(OP_W'(OP_PEEK + 1), $urandom, $urandom, $urandom, $urandom);
      queue_cmd(OP_W'(OP_PEEK + 2), $urandom, $urandom, $urandom, $urandom);
      queue_cmd(OP_W'(OP_LAST_CODE), $urandom, $urandom, $urandom, $urandom);
      queue_cmd(OP_PEEK, $urandom, $urandom, $urandom, DEPTH - 1);
      queue_cmd(OP_SET_BIT, $urandom, $urandom, 7, $urandom);
      queue_cmd(OP_READ, 1, $urandom, $urandom, $urandom);
      queue_drain();

      // Random: write/read-back sequences mixed with loose commands
      next_drain = useful_items + DRAIN_EVERY;
      while (useful_items < N_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            start = ($urandom_range(0, 7) == 0) ? ADDR_W'(DEPTH - 1 - $urandom_range(0, 5))
                                                : ADDR_W'($urandom);
            // start mid-byte only where the byte already holds data
            sbit = written[PLAN][start] ? $urandom_range(0, BYTE_W - 1) : 0;
            nfield = $urandom_range(1, 6);
            total = 0;
            queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, start);
            queue_cmd(OP_SET_BIT, $urandom, $urandom, sbit, $urandom);
            for (int i = 0; i < nfield; i++) begin
               cnts[i] = pick_count();
               total += (cnts[i] > MAXC) ? MAXC : cnts[i];
               queue_cmd(OP_WRITE, cnts[i], $urandom, $urandom, $urandom);
            end
            queue_cmd(OP_SET_BYTE, $urandom, $urandom, $urandom, start);
            queue_cmd(OP_SET_BIT, $urandom, $urandom, sbit, $urandom);
            for (int i = 0; i < nfield; i++)
               queue_cmd(OP_READ, cnts[i], $urandom, $urandom, $urandom);
            span = (sbit + total + BYTE_W - 1) / BYTE_W;
            if (span > 0) begin
               r = rand_req(OP_PEEK);
               r.addr = start + ADDR_W'($urandom_range(0, span - 1));
               if (is_safe(r)) queue_op(r);
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               r = rand_req(($urandom_range(0, 9) == 0)
                            ? OP_W'($urandom_range(OP_PEEK + 1, OP_LAST_CODE))
                            : OP_W'($urandom_range(OP_WRITE, OP_PEEK)));
               if (r.op == OP_PEEK && $urandom_range(0, 1) == 0)
                  r.addr = cur_byte[PLAN] - 1'b1;
               // anything reading unwritten bytes becomes a write, moved to bit 0 if still unsafe
               if (!is_safe(r)) begin
                  r.op = OP_WRITE;
                  if (!is_safe(r)) queue_cmd(OP_SET_BIT, $urandom, $urandom, 0, $urandom);
               end
               queue_op(r);
            end
         end
         if (useful_items >= next_drain) begin
            queue_drain();
            next_drain += DRAIN_EVERY;
         end
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while ((beats_done < stim_total || due_rsp.size() != 0) && stuck_cycles < STUCK_LIMIT)
         @(negedge clock);

      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles, %0d of %0d sent, %0d outstanding",
                  stuck_cycles, beats_done, stim_total, due_rsp.size());
         $display("*** FAILED ***");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         unused_ops = 0;
         for (int i = OP_PEEK + 1; i <= OP_LAST_CODE; i++) unused_ops += op_tally[i];
         $display("Covered %0d beats: %0d write, %0d read, %0d bit moves, %0d byte moves,",
                  beats_done, op_tally[OP_WRITE], op_tally[OP_READ], op_tally[OP_SET_BIT],
                  op_tally[OP_SET_BYTE]);
         $display("  %0d peek, %0d unused opcode; %0d responses checked, %0d mismatches",
                  op_tally[OP_PEEK], unused_ops, rsp_count, mismatches);
         if (mismatches == 0) $display("*** PASSED ***");
         else $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/lsbbuf_pkg.sv
rtl/lsbbuf_ctrl.sv
rtl/lsbbuf_dpath.sv
rtl/lsb_first_bit_stream_buffer_unit.sv
tb/lsb_first_bit_stream_buffer_unit_tb.sv
